// File: rtl/svpd_pkg.sv
`timescale 1ns / 1ps
package svpd_pkg;

	localparam int NUM_W = 47;
	localparam logic [15:0] DCV_RESET = 16'd6144;
	localparam logic [15:0] SQRT3_Q15 = 16'd56756;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// zero-based sector codes; the reported sector is code + 1
	localparam logic [2:0] SEC_1 = 3'd0;
	localparam logic [2:0] SEC_2 = 3'd1;
	localparam logic [2:0] SEC_3 = 3'd2;
	localparam logic [2:0] SEC_4 = 3'd3;
	localparam logic [2:0] SEC_5 = 3'd4;
	localparam logic [2:0] SEC_6 = 3'd5;

	typedef struct packed {
		logic [2:0]       sec;
		logic [NUM_W-1:0] num_ts;
		logic [NUM_W-1:0] num_1;
		logic [NUM_W-1:0] num_2;
	} job_t;

	// floored quotient by long division; only used to build constant tables
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned dvs);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dvs) begin
				r = r - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q15 sine of k/2^bits of sixty degrees, Q30 Taylor series of seven terms
	function automatic logic [15:0] sine_q15(input int unsigned bits, input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint sum;
		longint unsigned den;
		x = udiv64(PI_Q30 * longint'(k), 64'd3 << bits);
		term = x;
		sum = longint'(x);
		for (int i = 1; i <= 6; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			den = longint'((2 * i) * (2 * i + 1));
			term = udiv64(term, den);
			if ((i & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 16'((longint'(sum) + 64'd16384) >> 15);
	endfunction

endpackage

// File: rtl/svpd_if.sv
`timescale 1ns / 1ps
interface svpd_item_if;
	logic        valid;
	logic        ready;
	logic [15:0] ref_voltage;
	logic [15:0] rotor_angle;
	modport source (output valid, output ref_voltage, output rotor_angle, input ready);
	modport sink (input valid, input ref_voltage, input rotor_angle, output ready);
endinterface

interface svpd_result_if;
	logic        valid;
	logic        ready;
	logic [14:0] duty_phase_a;
	logic [14:0] duty_phase_b;
	logic [14:0] duty_phase_c;
	logic [2:0]  sector_number;
	modport source (output valid, output duty_phase_a, output duty_phase_b,
		output duty_phase_c, output sector_number, input ready);
	modport sink (input valid, input duty_phase_a, input duty_phase_b,
		input duty_phase_c, input sector_number, output ready);
endinterface

// File: rtl/svpd_front.sv
`timescale 1ns / 1ps
module svpd_front import svpd_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	svpd_item_if.sink   item,
	output logic        push,
	output job_t        job,
	input  logic        q_ready
);
	localparam int B = SINE_TABLE_BITS;
	localparam int N = 1 << B;

	typedef logic [15:0] sine_tab_t [0:N];

	function automatic sine_tab_t build_tab();
		sine_tab_t t;
		for (int k = 0; k <= N; k++) begin
			t[k] = sine_q15(B, k);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE = build_tab();

	logic        v_s1, v_s2, v_s3;
	logic [2:0]  sec_s1, sec_s2;
	logic [B-1:0] u_s1;
	logic [31:0] k_s1, k_s2;
	logic [15:0] sa_s2, sb_s2;
	job_t        job_s3;
	logic        en;
	logic [18:0] p;
	logic [B:0]  u_mirror;
	logic [47:0] prod_1, prod_2;

	assign en = !v_s3 || q_ready;
	assign item.ready = en;
	assign push = v_s3 && q_ready;
	assign job = job_s3;

	assign p = 19'(item.rotor_angle) * 19'd6;
	assign u_mirror = (B+1)'(N) - {1'b0, u_s1};
	assign prod_1 = 48'(k_s2) * 48'(sa_s2);
	assign prod_2 = 48'(k_s2) * 48'(sb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1 <= p[18:16];
			u_s1   <= p[15:16-B];
			k_s1   <= 32'(item.ref_voltage) * 32'(SQRT3_Q15);
			sec_s2 <= sec_s1;
			k_s2   <= k_s1;
			sa_s2  <= SINE[u_mirror];
			sb_s2  <= SINE[u_s1];
			job_s3.sec    <= sec_s2;
			job_s3.num_ts <= {k_s2, 15'd0};
			job_s3.num_1  <= prod_1[NUM_W-1:0];
			job_s3.num_2  <= prod_2[NUM_W-1:0];
		end
	end
endmodule

// File: rtl/svpd_queue.sv
`timescale 1ns / 1ps
module svpd_queue import svpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic ready,
	input  logic pop,
	output logic valid,
	output job_t rd_job
);
	job_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign ready  = cnt_q != 3'd4;
	assign valid  = cnt_q != 3'd0;
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_job;
	end
endmodule

// File: rtl/svpd_back.sv
`timescale 1ns / 1ps
module svpd_back import svpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   den,
	input  logic          q_valid,
	input  job_t          q_job,
	output logic          pop,
	svpd_result_if.source result
);
	localparam int W = NUM_W;

	logic           v_q   [W+1];
	logic [2:0]     sec_q [W+1];
	logic [15:0]    r_q   [3][W+1];
	logic [W-1:0]   nq_q  [3][W+1];
	logic           en;
	logic           out_v_q;

	assign en = !out_v_q || result.ready;
	assign pop = en && q_valid;
	assign result.valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= W; j++) v_q[j] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= q_valid;
			for (int j = 1; j <= W; j++) v_q[j] <= v_q[j-1];
			out_v_q <= v_q[W];
		end
	end

	// load the three numerators, then retire one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			sec_q[0] <= q_job.sec;
			nq_q[0][0] <= q_job.num_ts;
			nq_q[1][0] <= q_job.num_1;
			nq_q[2][0] <= q_job.num_2;
			for (int l = 0; l < 3; l++) r_q[l][0] <= 16'd0;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_div
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [16:0] tmp;
			logic        qb;
			assign tmp = {r_q[l][j-1], nq_q[l][j-1][W-1]};
			assign qb  = tmp >= {1'b0, den};
			always_ff @(posedge clk) begin
				if (en) begin
					r_q[l][j]  <= qb ? 16'(tmp - {1'b0, den}) : tmp[15:0];
					nq_q[l][j] <= {nq_q[l][j-1][W-2:0], qb};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) sec_q[j] <= sec_q[j-1];
		end
	end

	function automatic logic [14:0] sat(input logic signed [W+2:0] v);
		logic [14:0] d;
		if (v < 0) begin
			d = 15'd0;
		end else if (v > (W+3)'(64'sd2147483647)) begin
			d = 15'h7FFF;
		end else begin
			d = v[30:16];
		end
		return d;
	endfunction

	logic signed [W+2:0] ts, t1, t2, t0, z, d1, d2, d12;
	logic signed [W+2:0] da, db, dc;

	always_comb begin
		ts  = (W+3)'(nq_q[0][W]);
		t1  = (W+3)'(nq_q[1][W]);
		t2  = (W+3)'(nq_q[2][W]);
		t0  = ts - t1 - t2;
		z   = t0;
		d1  = 2 * t1 + t0;
		d2  = 2 * t2 + t0;
		d12 = 2 * t1 + 2 * t2 + t0;
		unique case (sec_q[W])
			SEC_1:   begin da = d12; db = d2;  dc = z;   end
			SEC_2:   begin da = d1;  db = d12; dc = z;   end
			SEC_3:   begin da = z;   db = d12; dc = d2;  end
			SEC_4:   begin da = z;   db = d1;  dc = d12; end
			SEC_5:   begin da = d2;  db = z;   dc = d12; end
			default: begin da = d12; db = z;   dc = d1;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.duty_phase_a  <= sat(da);
			result.duty_phase_b  <= sat(db);
			result.duty_phase_c  <= sat(dc);
			result.sector_number <= sec_q[W] + 3'd1;
		end
	end
endmodule

// File: rtl/space_vector_pwm_duty_core.sv
`timescale 1ns / 1ps
// Path: three front registers, one queue slot, the divider stages and the
// output register. Throughput: one word per cycle while the result sink is
// ready, set by the bit-per-stage divider pipeline; back-pressure stalls it.
// Reset: arst_n clears all valid flags and the queue and sets the bus voltage
// register to 24 V; no table fill is needed, the sine table is constant.
module space_vector_pwm_duty_core import svpd_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	svpd_item_if.sink     item,
	svpd_result_if.source result
);
	logic [15:0] dcv_q;
	logic [15:0] den;
	logic        push, q_ready, q_valid, pop;
	job_t        wr_job, rd_job;

	// hold the bus voltage; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcv_q <= DCV_RESET;
		end else if (cfg_we) begin
			dcv_q <= cfg_wdata;
		end
	end

	// treat a zero bus voltage as one
	assign den = (dcv_q == 16'd0) ? 16'd1 : dcv_q;

	// front: sector, sine lookups, numerators ts, t1, t2
	svpd_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.push    (push),
		.job     (wr_job),
		.q_ready (q_ready)
	);

	// decouple the front from the divider pipeline
	svpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.ready  (q_ready),
		.pop    (pop),
		.valid  (q_valid),
		.rd_job (rd_job)
	);

	// back: divide by the bus voltage, route per sector, saturate
	svpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.den     (den),
		.q_valid (q_valid),
		.q_job   (rd_job),
		.pop     (pop),
		.result  (result)
	);
endmodule

// File: verif/tb_space_vector_pwm_duty_core.sv
`timescale 1ns / 1ps
module tb_space_vector_pwm_duty_core;
	import svpd_pkg::*;

	localparam int TBL_BITS = 10;
	localparam int LATENCY = 60;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_WORDS = 850;

	typedef struct packed {
		logic [14:0] pa;
		logic [14:0] pb;
		logic [14:0] pc;
		logic [2:0]  sec;
	} duty_set_t;

	// one row of the directed table; a known row carries a typed-in answer
	typedef struct {
		logic        is_cfg;
		logic [15:0] a;
		logic [15:0] b;
		logic        known;
		duty_set_t   ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	svpd_item_if   item_ch ();
	svpd_result_if result_ch ();

	space_vector_pwm_duty_core #(.SINE_TABLE_BITS(TBL_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch.sink),
		.result   (result_ch.source)
	);

	always #5 clk = ~clk;

	// predictor state: its own bus voltage copy and sine table
	logic [15:0] bus_volts;
	logic [15:0] sin_tab [0:(1 << TBL_BITS)];
	duty_set_t   pending_duties [$];
	int          mismatches = 0;
	int          words_checked = 0;
	int          idle_cycles = 0;
	logic        rx_stall_mode = 1'b0;

	// Build the Q15 table of sin(k/2^B * 60deg) with a Q30 Taylor series.
	task automatic fill_sine();
		longint unsigned x, term;
		longint acc;
		for (int k = 0; k <= (1 << TBL_BITS); k++) begin
			x = (PI_Q30 * longint'(k)) / (64'd3 << TBL_BITS);
			term = x;
			acc = longint'(x);
			for (int i = 1; i <= 6; i++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / longint'((2 * i) * (2 * i + 1));
				if (i % 2 == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			sin_tab[k] = 16'((longint'(acc) + 16384) >> 15);
		end
	endtask

	function automatic logic [14:0] clamp_duty(input longint v);
		if (v < 0) v = 0;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		return 15'(v >> 16);
	endfunction

	// Seven-segment duty split for one reference vector.
	function automatic duty_set_t svm_duties(input logic [15:0] vref, input logic [15:0] ang);
		longint unsigned pos, kv, den, ts, t1, t2;
		int unsigned seg, frac;
		longint t0, z, d1, d2, d12, da, db, dc;
		duty_set_t r;
		den = (bus_volts == 0) ? 1 : longint'(bus_volts);
		pos = longint'(ang) * 6;
		seg = int'(pos >> 16);
		frac = int'((pos & 16'hFFFF) >> (16 - TBL_BITS));
		kv = longint'(vref) * longint'(SQRT3_Q15);
		ts = (kv << 15) / den;
		t1 = (kv * sin_tab[(1 << TBL_BITS) - frac]) / den;
		t2 = (kv * sin_tab[frac]) / den;
		t0 = longint'(ts) - longint'(t1) - longint'(t2);
		z = t0;
		d1 = 2 * longint'(t1) + t0;
		d2 = 2 * longint'(t2) + t0;
		d12 = 2 * longint'(t1) + 2 * longint'(t2) + t0;
		case (3'(seg))
			SEC_1: begin da = d12; db = d2; dc = z; end
			SEC_2: begin da = d1; db = d12; dc = z; end
			SEC_3: begin da = z; db = d12; dc = d2; end
			SEC_4: begin da = z; db = d1; dc = d12; end
			SEC_5: begin da = d2; db = z; dc = d12; end
			default: begin da = d12; db = z; dc = d1; end
		endcase
		r.pa = clamp_duty(da);
		r.pb = clamp_duty(db);
		r.pc = clamp_duty(dc);
		r.sec = 3'(seg + 1);
		return r;
	endfunction

	// Present one word; hold it until accepted, optionally leave a gap after.
	task automatic send_word(input logic [15:0] vref, input logic [15:0] ang, input int gap);
		item_ch.valid <= 1'b1;
		item_ch.ref_voltage <= vref;
		item_ch.rotor_angle <= ang;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain everything expected, let the pipe settle, then write the bus voltage.
	task automatic write_bus(input logic [15:0] v);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_duties.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		bus_volts = v;
	endtask

	// Receiver: stall in phases, sometimes always ready, sometimes random.
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) rx_stall_mode <= ~rx_stall_mode;
		if (!rx_stall_mode) result_ch.ready <= 1'b1;
		else result_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	// Checker: compare each result word with the oldest expectation.
	always @(posedge clk) begin
		duty_set_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.pa = result_ch.duty_phase_a;
			got.pb = result_ch.duty_phase_b;
			got.pc = result_ch.duty_phase_c;
			got.sec = result_ch.sector_number;
			words_checked++;
			if (pending_duties.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
			end else begin
				want = pending_duties.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected a=%0d b=%0d c=%0d s=%0d, got a=%0d b=%0d c=%0d s=%0d",
							want.pa, want.pb, want.pc, want.sec,
							got.pa, got.pb, got.pc, got.sec);
				end
			end
		end
	end

	// Track acceptance on the input side; push prediction; run the watchdog.
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			pending_duties.push_back(svm_duties(item_ch.ref_voltage, item_ch.rotor_angle));
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	row_t dir_rows [$];
	initial begin
		row_t rw;
		duty_set_t exp_dir;
		logic [15:0] bus_set [6];
		int burst, n;
		item_ch.valid = 1'b0;
		item_ch.ref_voltage = '0;
		item_ch.rotor_angle = '0;
		result_ch.ready = 1'b0;
		bus_volts = DCV_RESET;
		fill_sine();
		// zero reference: every duty is zero, only the sector moves
		rw = '{1'b0, 16'd0, 16'd0, 1'b1, '{15'd0, 15'd0, 15'd0, 3'd1}}; dir_rows.push_back(rw);
		rw = '{1'b0, 16'd0, 16'hFFFF, 1'b1, '{15'd0, 15'd0, 15'd0, 3'd6}}; dir_rows.push_back(rw);
		// deep overmodulation at the reset bus voltage saturates every phase high
		rw = '{1'b0, 16'hFFFF, 16'd0, 1'b1, '{15'h7FFF, 15'h7FFF, 15'h7FFF, 3'd1}};
		dir_rows.push_back(rw);
		// sector boundaries and mid points, modest reference
		for (int s = 0; s < 6; s++) begin
			rw = '{1'b0, 16'd1536, 16'((s * 65536 + 5) / 6), 1'b0, '0}; dir_rows.push_back(rw);
			rw = '{1'b0, 16'd2048, 16'((s * 65536 + 32768) / 6), 1'b0, '0};
			dir_rows.push_back(rw);
		end
		// bus voltage zero behaves as one; minimum and maximum register values
		rw = '{1'b1, 16'd0, 16'd0, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b0, 16'd1, 16'd4000, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b1, 16'hFFFF, 16'd0, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b0, 16'hFFFF, 16'h5555, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b0, 16'h00FF, 16'hAAAA, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b1, 16'd256, 16'd0, 1'b0, '0}; dir_rows.push_back(rw);
		rw = '{1'b0, 16'd100, 16'd20000, 1'b0, '0}; dir_rows.push_back(rw);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; known rows also check the predictor
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_bus(dir_rows[i].a);
			end else begin
				if (dir_rows[i].known) begin
					exp_dir = svm_duties(dir_rows[i].a, dir_rows[i].b);
					if (exp_dir !== dir_rows[i].ans) begin
						mismatches++;
						if (mismatches <= 10)
							$display("table row %0d: expected %p, predictor %p",
								i, dir_rows[i].ans, exp_dir);
					end
				end
				send_word(dir_rows[i].a, dir_rows[i].b, $urandom_range(0, 2));
			end
		end

		// random phases over a spread of bus voltages, extremes included
		bus_set = '{16'd6144, 16'd256, 16'hFFFF, 16'd12000, 16'd0, 16'd3000};
		n = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_bus(bus_set[ph]);
			while (n < (ph + 1) * RANDOM_WORDS / 6) begin
				burst = $urandom_range(1, 20);
				for (int j = 0; j < burst; j++) begin
					logic [15:0] v;
					// mostly linear range relative to the bus, sometimes anything
					if ($urandom_range(0, 3) == 0) v = 16'($urandom);
					else v = 16'($urandom_range(0, (bus_volts == 0) ? 1 : bus_volts / 2 + 1));
					send_word(v, 16'($urandom), (j == burst - 1) ? $urandom_range(0, 8) : 0);
					n++;
				end
			end
		end
		item_ch.valid <= 1'b0;

		fork
			begin
				while (pending_duties.size() != 0) @(posedge clk);
				repeat (LATENCY) @(posedge clk);
			end
			begin
				repeat (LATENCY * 200) @(posedge clk);
				mismatches++;
				$display("drain timed out with %0d words outstanding", pending_duties.size());
			end
		join_any
		disable fork;

		$display("Covered %0d checked result words across all six sectors and six bus settings,",
			words_checked);
		$display("with saturation, zero bus voltage and random source gaps and sink stalls.");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
